// ----- rtl/core/mqrb_pkg.sv -----
// Shared types and constants for the multi-queue ring buffer.
// Depends on nothing; imported by multi_queue_ring_buffer_top.
`default_nettype none

package mqrb_pkg;

    localparam int DEF_NUM_QUEUES  = 8;
    localparam int DEF_QUEUE_DEPTH = 16;

    // Request field layout in s_tdata
    localparam int OPCODE_W   = 3;
    localparam int QUEUE_ID_W = 4;
    localparam int ELEM_W     = 32;
    localparam int PAYLOAD_W  = 32;
    localparam int IN_BITS    = OPCODE_W + QUEUE_ID_W + ELEM_W + PAYLOAD_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Response field layout in m_tdata
    localparam int STATUS_W    = 2;
    localparam int ALLOC_W     = 3;
    localparam int OUT_BITS    = STATUS_W + ALLOC_W + 1 + ELEM_W + PAYLOAD_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_RELEASE = 3'd1,
        OP_PUSH    = 3'd2,
        OP_POP     = 3'd3,
        OP_QUERY   = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOFREE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } fsm_t;

endpackage

`default_nettype wire

// ----- rtl/core/multi_queue_ring_buffer_top.sv -----
// Pool of ring queues with allocate/release/push/pop/query requests.
// Depends on mqrb_pkg.
//
// Response: registered in the cycle after the request transfer; a pop that
// returns an element is read into rdata_reg first, then into the output register.
// Throughput: one request per cycle while the output is not stalled, except a
// pop returning data, which holds off requests in S_READ; set by the registered read.
// Reset (rst_n low, asynchronous): all queues free, pointers and counts zero.
// No clearing pass: slot occupancy follows from each queue's fill count.
`default_nettype none

module multi_queue_ring_buffer_top #(
    parameter int NUM_QUEUES  = mqrb_pkg::DEF_NUM_QUEUES,
    parameter int QUEUE_DEPTH = mqrb_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // s_tdata, from bit 0: opcode[3], queue_id[4], element_id[32], payload[32], zero fill
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [mqrb_pkg::IN_TDATA_W-1:0]   s_tdata,
    // m_tdata, from bit 0: status[2], allocated_id[3], data_valid[1],
    // out_element_id[32], out_payload[32], is_empty[1], zero fill
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [mqrb_pkg::OUT_TDATA_W-1:0]       m_tdata
);
    import mqrb_pkg::*;

    localparam int QIW       = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW        = $clog2(QUEUE_DEPTH);
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_SLOTS = NUM_QUEUES * QUEUE_DEPTH;
    localparam int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MEM_W     = ELEM_W + PAYLOAD_W;

    // Per-queue control state: small, indexed by the request's queue id
    logic [NUM_QUEUES-1:0] in_use_reg, in_use_next;
    logic [PW-1:0]         wp_reg  [NUM_QUEUES];
    logic [PW-1:0]         wp_next [NUM_QUEUES];
    logic [PW-1:0]         rp_reg  [NUM_QUEUES];
    logic [PW-1:0]         rp_next [NUM_QUEUES];
    // Fill count per queue: occupied slots are the run of cnt slots from rp
    logic [CW-1:0]         cnt_reg  [NUM_QUEUES];
    logic [CW-1:0]         cnt_next [NUM_QUEUES];

    fsm_t state_reg, state_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Slot memory: element id in the low word, payload in the high word
    logic [MEM_W-1:0] slot_mem [NUM_SLOTS];
    logic [MEM_W-1:0] rdata_reg;
    logic             mem_we;
    logic             mem_re;
    logic [SW-1:0]    mem_waddr;
    logic [SW-1:0]    mem_raddr;
    logic [MEM_W-1:0] mem_wdata;

    // Request fields
    logic [OPCODE_W-1:0]   req_op;
    logic [QUEUE_ID_W-1:0] req_qid;
    logic [ELEM_W-1:0]     req_elem;
    logic [PAYLOAD_W-1:0]  req_pay;

    logic          accept;
    logic          out_free;
    logic          in_range;
    logic [QIW-1:0] qi;
    logic          usable;
    logic [PW-1:0] cur_wp;
    logic [PW-1:0] cur_rp;
    logic [CW-1:0] cur_cnt;
    logic          q_full;
    logic          q_empty;

    assign req_op   = s_tdata[OPCODE_W-1:0];
    assign req_qid  = s_tdata[OPCODE_W +: QUEUE_ID_W];
    assign req_elem = s_tdata[OPCODE_W+QUEUE_ID_W +: ELEM_W];
    assign req_pay  = s_tdata[OPCODE_W+QUEUE_ID_W+ELEM_W +: PAYLOAD_W];

    // Output register parts the sides: take a request while the last
    // response is being drained.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_range = {1'b0, req_qid} < (QUEUE_ID_W + 1)'(NUM_QUEUES);
    assign qi       = in_range ? req_qid[QIW-1:0] : '0;
    assign usable   = in_range && in_use_reg[qi];
    assign cur_wp   = wp_reg[qi];
    assign cur_rp   = rp_reg[qi];
    assign cur_cnt  = cnt_reg[qi];
    assign q_full   = (cur_cnt == CW'(QUEUE_DEPTH));
    assign q_empty  = (cur_cnt == '0);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [SW-1:0] slot_addr(input logic [QIW-1:0] q,
                                                input logic [PW-1:0] p);
        slot_addr = SW'(SW'(q) * SW'(QUEUE_DEPTH)) + SW'(p);
    endfunction

    function automatic logic [OUT_TDATA_W-1:0] pack_resp(
        input status_t              st,
        input logic [ALLOC_W-1:0]   aid,
        input logic                 dv,
        input logic [ELEM_W-1:0]    el,
        input logic [PAYLOAD_W-1:0] pl,
        input logic                 emp
    );
        pack_resp = OUT_TDATA_W'({emp, pl, el, dv, aid, st});
    endfunction

    always_comb
    begin
        logic                  found;
        logic [QUEUE_ID_W-1:0] free_idx;
        status_t               st;
        logic [ALLOC_W-1:0]    aid;
        logic                  emp;

        found    = 1'b0;
        free_idx = '0;
        st       = ST_INVALID;
        aid      = '0;
        emp      = 1'b0;

        in_use_next = in_use_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        cnt_next    = cnt_reg;
        state_next  = state_reg;

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = slot_addr(qi, cur_wp);
        mem_raddr = slot_addr(qi, cur_rp);
        mem_wdata = {req_pay, req_elem};

        // Lowest free queue: search from the top so the lowest match wins
        for (int i = NUM_QUEUES - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                found    = 1'b1;
                free_idx = QUEUE_ID_W'(i);
            end
        end

        // Drop the response once taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_op)
                        OP_ALLOC:
                        begin
                            if (found)
                            begin
                                in_use_next[free_idx[QIW-1:0]] = 1'b1;
                                aid = free_idx[ALLOC_W-1:0];
                                st  = ST_OK;
                            end
                            else
                            begin
                                st = ST_NOFREE;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (in_range)
                            begin
                                in_use_next[qi] = 1'b0;
                                st = ST_OK;
                            end
                        end
                        OP_PUSH:
                        begin
                            if (usable)
                            begin
                                if (q_full)
                                begin
                                    st = ST_FULL;
                                end
                                else
                                begin
                                    mem_we       = 1'b1;
                                    wp_next[qi]  = ptr_inc(cur_wp);
                                    cnt_next[qi] = cur_cnt + CW'(1);
                                    st = ST_OK;
                                end
                            end
                        end
                        OP_POP:
                        begin
                            if (usable)
                            begin
                                st = ST_OK;
                                if (!q_empty)
                                begin
                                    // Read the head slot; respond from S_READ
                                    mem_re       = 1'b1;
                                    rp_next[qi]  = ptr_inc(cur_rp);
                                    cnt_next[qi] = cur_cnt - CW'(1);
                                    state_next   = S_READ;
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            if (usable)
                            begin
                                st  = ST_OK;
                                emp = q_empty;
                            end
                            else
                            begin
                                emp = 1'b1;
                            end
                        end
                        default:
                        begin
                            st = ST_INVALID;
                        end
                    endcase

                    if (!mem_re)
                    begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = pack_resp(st, aid, 1'b0, '0, '0, emp);
                    end
                end
            end
            S_READ:
            begin
                // Hold the read data until the output register is free
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pack_resp(ST_OK, '0, 1'b1,
                                              rdata_reg[ELEM_W-1:0],
                                              rdata_reg[MEM_W-1:ELEM_W], 1'b0);
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            in_use_reg   <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                wp_reg[i]  <= '0;
                rp_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            in_use_reg   <= in_use_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    // Slot memory, one write and one read port, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= slot_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire
